/* sv/pse_pkg.sv */
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and the helper function of the particle slice extractor.
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int SliceW     = 64;
	localparam int TimeW      = 37;
	localparam int DeltaW     = 38;
	localparam int WidthW     = 16;
	localparam int HeightW    = 7;
	localparam int AreaW      = 22;
	localparam int EdgeW      = 16;
	localparam int SliceCntW  = 7;
	localparam int CfgIndexW  = 2;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);

	// Configuration register indexes.
	localparam logic [CfgIndexW-1:0] CFG_SYNC_MASK        = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_SYNC_PATTERN     = 2'd1;
	localparam logic [CfgIndexW-1:0] CFG_OVERLOAD_PATTERN = 2'd2;

	localparam logic [SliceW-1:0] SyncMaskReset = 64'hFFFF_FF00_0000_0000;

	// Result kinds.
	localparam logic KIND_PARTICLE = 1'b0;
	localparam logic KIND_OVERLOAD = 1'b1;

	// Reciprocal of 3 scaled by 2^11; exact for dividends below 768.
	localparam logic [19:0] Div3Recip = 20'd683;

	typedef enum logic [1:0] {
		CLS_IMAGE,
		CLS_SYNC,
		CLS_OVLD,
		CLS_SKIP
	} pse_cls_t;

	typedef struct packed {
		pse_cls_t               cls;
		logic [TimeW-1:0]       time_us;
		logic [SliceCntW-1:0]   area;
		logic [HeightW-1:0]     height;
		logic                   top;
		logic                   bottom;
	} pse_item_t;

	// One long-division digit by 3: returns {quotient byte, remainder}.
	function automatic logic [9:0] div3_step(logic [1:0] rem, logic [7:0] digit);
		logic [9:0]  v;
		logic [19:0] p;
		logic [7:0]  q;
		logic [9:0]  r;
		v = {rem, digit};
		p = {10'd0, v} * Div3Recip;
		q = p[18:11];
		r = v - ({2'd0, q} * 10'd3);
		return {q, r[1:0]};
	endfunction

endpackage

/* sv/particle_slice_extractor_64_unit.sv */
// A sync or overload slice becomes a result via the input and classifier registers,
// the queue and the output register. Throughput: one slice per cycle while the queue
// has room, set by the two-stage classifier and the particle update in the back end.
// The four-entry queue lets the classifier keep running while a result is stalled.
// Reset is asynchronous and active low; it restores the default sync mask and
// clears the patterns, the particle and the last sync time.
// ----------------------------------------------------------------------------
// particle_slice_extractor_64_unit
// Extracts particle statistics and overload reports from optical array probe
// slices: a front end classifies slices, a queue decouples it from the back end.
// ----------------------------------------------------------------------------
module particle_slice_extractor_64_unit #(
	parameter int DIODE_COUNT = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [pse_pkg::SliceW-1:0]         slice_bits,
	input  logic                               cfg_write,
	input  logic [pse_pkg::CfgIndexW-1:0]      cfg_index,
	input  logic [pse_pkg::SliceW-1:0]         cfg_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               result_kind,
	output logic [pse_pkg::TimeW-1:0]          time_us,
	output logic signed [pse_pkg::DeltaW-1:0]  delta_us,
	output logic [pse_pkg::WidthW-1:0]         particle_width,
	output logic [pse_pkg::HeightW-1:0]        particle_height,
	output logic [pse_pkg::AreaW-1:0]          particle_area,
	output logic                               touched_top_edge,
	output logic                               touched_bottom_edge,
	output logic [pse_pkg::EdgeW-1:0]          top_edge_count,
	output logic [pse_pkg::EdgeW-1:0]          bottom_edge_count
);
	import pse_pkg::*;

	logic      q_full;
	logic      q_push;
	pse_item_t q_item;
	logic      head_valid;
	pse_item_t head_item;
	logic      pop;

	pse_front #(
		.DIODE_COUNT(DIODE_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.slice_bits(slice_bits),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_item)
	);

	pse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_item   (q_item),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	pse_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.head_valid         (head_valid),
		.head_item          (head_item),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.result_kind        (result_kind),
		.time_us            (time_us),
		.delta_us           (delta_us),
		.particle_width     (particle_width),
		.particle_height    (particle_height),
		.particle_area      (particle_area),
		.touched_top_edge   (touched_top_edge),
		.touched_bottom_edge(touched_bottom_edge),
		.top_edge_count     (top_edge_count),
		.bottom_edge_count  (bottom_edge_count)
	);

	// Skip slices must never reach the queue.
	a_no_skip_queued: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> head_item.cls != CLS_SKIP)
		else $error("skip slice found in queue");

	// Popping a sync or overload item always loads a result.
	a_report_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_item.cls != CLS_IMAGE) |=> out_valid)
		else $error("report item popped without a result");

	// Overload reports carry no particle statistics.
	a_overload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_OVERLOAD) |->
		(particle_width == '0 && particle_height == '0 && particle_area == '0))
		else $error("overload report with particle data");

	// Height can never exceed the number of diodes.
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> particle_height <= HeightW'(DIODE_COUNT))
		else $error("particle height out of range");

endmodule

/* sv/pse_front.sv */
// ----------------------------------------------------------------------------
// pse_front
// Accepts probe slices, classifies them against the sync and overload patterns,
// measures shadow statistics and converts the time word to microseconds.
// ----------------------------------------------------------------------------
module pse_front #(
	parameter int DIODE_COUNT = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pse_pkg::SliceW-1:0]     slice_bits,
	input  logic                           cfg_write,
	input  logic [pse_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [pse_pkg::SliceW-1:0]     cfg_data,
	input  logic                           q_full,
	output logic                           q_push,
	output pse_pkg::pse_item_t             q_item
);
	import pse_pkg::*;

	localparam logic [SliceW-1:0] DiodeMask =
		(DIODE_COUNT >= SliceW) ? {SliceW{1'b1}} : ((64'd1 << DIODE_COUNT) - 64'd1);
	localparam int TopBit = DIODE_COUNT - 1;

	logic [SliceW-1:0] sync_mask_q;
	logic [SliceW-1:0] sync_pattern_q;
	logic [SliceW-1:0] overload_pattern_q;

	logic              valid_s1;
	logic [SliceW-1:0] slice_s1;

	logic                 valid_s2;
	pse_cls_t             cls_s2;
	logic [SliceCntW-1:0] area_s2;
	logic [HeightW-1:0]   height_s2;
	logic                 top_s2;
	logic                 bottom_s2;
	logic [23:0]          qhi_s2;
	logic [1:0]           rem_s2;
	logic [15:0]          ylo_s2;

	logic ready_s1;
	logic ready_s2;

	pse_cls_t             cls_d;
	logic [SliceW-1:0]    masked;
	logic [SliceW-1:0]    shadow;
	logic [SliceCntW-1:0] area_d;
	logic [5:0]           msb_idx;
	logic [5:0]           lsb_idx;
	logic [HeightW-1:0]   height_d;
	logic [39:0]          ticks4;
	logic [9:0]           st4;
	logic [9:0]           st3;
	logic [9:0]           st2;
	logic [9:0]           st1;
	logic [9:0]           st0;
	logic [39:0]          quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_mask_q        <= SyncMaskReset;
			sync_pattern_q     <= '0;
			overload_pattern_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SYNC_MASK:        sync_mask_q        <= cfg_data;
				CFG_SYNC_PATTERN:     sync_pattern_q     <= cfg_data;
				CFG_OVERLOAD_PATTERN: overload_pattern_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Skip slices retire at the second stage without taking a queue entry.
	assign ready_s2 = !valid_s2 || (cls_s2 == CLS_SKIP) || !q_full;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;
	assign q_push   = valid_s2 && (cls_s2 != CLS_SKIP) && !q_full;

	always_comb begin
		masked = slice_s1 & sync_mask_q;
		priority if (masked == sync_pattern_q) begin
			cls_d = CLS_SYNC;
		end else if (masked == overload_pattern_q) begin
			cls_d = CLS_OVLD;
		end else if (slice_s1 == {SliceW{1'b1}}) begin
			cls_d = CLS_SKIP;
		end else begin
			cls_d = CLS_IMAGE;
		end
	end

	always_comb begin
		shadow  = ~slice_s1 & DiodeMask;
		area_d  = '0;
		msb_idx = '0;
		lsb_idx = '0;
		for (int j = 0; j < SliceW; j++) begin
			area_d = area_d + SliceCntW'(shadow[j]);
		end
		for (int j = 0; j < DIODE_COUNT; j++) begin
			if (shadow[j]) msb_idx = 6'(j);
		end
		for (int j = DIODE_COUNT - 1; j >= 0; j--) begin
			if (shadow[j]) lsb_idx = 6'(j);
		end
		// The span runs from the highest to the lowest shadowed diode.
		if (shadow == '0) begin
			height_d = '0;
		end else begin
			height_d = {1'b0, msb_idx} - {1'b0, lsb_idx} + 7'd1;
		end
	end

	// The time word over 12 is the word over 4, then divided by 3 a byte at a time.
	assign ticks4 = {2'd0, slice_s1[39:2]};
	assign st4 = div3_step(2'd0, ticks4[39:32]);
	assign st3 = div3_step(st4[1:0], ticks4[31:24]);
	assign st2 = div3_step(st3[1:0], ticks4[23:16]);
	assign st1 = div3_step(rem_s2, ylo_s2[15:8]);
	assign st0 = div3_step(st1[1:0], ylo_s2[7:0]);
	assign quot = {qhi_s2, st1[9:2], st0[9:2]};

	always_comb begin
		q_item         = '0;
		q_item.cls     = cls_s2;
		q_item.time_us = quot[TimeW-1:0];
		q_item.area    = area_s2;
		q_item.height  = height_s2;
		q_item.top     = top_s2;
		q_item.bottom  = bottom_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) slice_s1 <= slice_bits;
		if (valid_s1 && ready_s2) begin
			cls_s2    <= cls_d;
			area_s2   <= area_d;
			height_s2 <= height_d;
			top_s2    <= shadow[TopBit];
			bottom_s2 <= shadow[0];
			qhi_s2    <= {st4[9:2], st3[9:2], st2[9:2]};
			rem_s2    <= st2[1:0];
			ylo_s2    <= ticks4[15:0];
		end
	end

endmodule

/* sv/pse_queue.sv */
// ----------------------------------------------------------------------------
// pse_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module pse_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pse_pkg::pse_item_t wr_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output pse_pkg::pse_item_t head_item
);
	import pse_pkg::*;

	pse_item_t              entry_q [QueueDepth];
	logic [QueuePtrW-1:0]   wr_ptr_q;
	logic [QueuePtrW-1:0]   rd_ptr_q;
	logic [QueuePtrW:0]     count_q;

	assign full       = (count_q == (QueuePtrW+1)'(QueueDepth));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wr_item;
	end

endmodule

/* sv/pse_back.sv */
// ----------------------------------------------------------------------------
// pse_back
// Accumulates the particle from image items and reports particles and
// overloads through the output register.
// ----------------------------------------------------------------------------
module pse_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               head_valid,
	input  pse_pkg::pse_item_t                 head_item,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               result_kind,
	output logic [pse_pkg::TimeW-1:0]          time_us,
	output logic signed [pse_pkg::DeltaW-1:0]  delta_us,
	output logic [pse_pkg::WidthW-1:0]         particle_width,
	output logic [pse_pkg::HeightW-1:0]        particle_height,
	output logic [pse_pkg::AreaW-1:0]          particle_area,
	output logic                               touched_top_edge,
	output logic                               touched_bottom_edge,
	output logic [pse_pkg::EdgeW-1:0]          top_edge_count,
	output logic [pse_pkg::EdgeW-1:0]          bottom_edge_count
);
	import pse_pkg::*;

	logic [WidthW-1:0]  width_count_q;
	logic [HeightW-1:0] height_max_q;
	logic [AreaW-1:0]   area_sum_q;
	logic               top_flag_q;
	logic               bottom_flag_q;
	logic [EdgeW-1:0]   top_count_q;
	logic [EdgeW-1:0]   bottom_count_q;
	logic [TimeW-1:0]   last_sync_time_q;

	logic               out_valid_q;
	logic               kind_q;
	logic [TimeW-1:0]   time_q;
	logic [DeltaW-1:0]  delta_q;
	logic [WidthW-1:0]  width_q;
	logic [HeightW-1:0] height_q;
	logic [AreaW-1:0]   area_q;
	logic               top_q;
	logic               bottom_q;
	logic [EdgeW-1:0]   top_cnt_q;
	logic [EdgeW-1:0]   bottom_cnt_q;

	logic               is_image;
	logic               out_free;
	logic [AreaW:0]     area_add;
	logic [DeltaW-1:0]  delta_d;

	assign is_image = (head_item.cls == CLS_IMAGE);
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = head_valid && (is_image || out_free);
	assign area_add = {1'b0, area_sum_q} + (AreaW+1)'(head_item.area);
	assign delta_d  = {1'b0, head_item.time_us} - {1'b0, last_sync_time_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q      <= 1'b0;
			width_count_q    <= '0;
			height_max_q     <= '0;
			area_sum_q       <= '0;
			top_flag_q       <= 1'b0;
			bottom_flag_q    <= 1'b0;
			top_count_q      <= '0;
			bottom_count_q   <= '0;
			last_sync_time_q <= '0;
		end else begin
			if (pop && !is_image) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (head_item.cls)
					CLS_IMAGE: begin
						if (width_count_q != '1) width_count_q <= width_count_q + 1'b1;
						if (head_item.height > height_max_q) height_max_q <= head_item.height;
						area_sum_q <= area_add[AreaW] ? '1 : area_add[AreaW-1:0];
						if (head_item.top) begin
							top_flag_q <= 1'b1;
							if (top_count_q != '1) top_count_q <= top_count_q + 1'b1;
						end
						if (head_item.bottom) begin
							bottom_flag_q <= 1'b1;
							if (bottom_count_q != '1) bottom_count_q <= bottom_count_q + 1'b1;
						end
					end
					CLS_SYNC: begin
						width_count_q    <= '0;
						height_max_q     <= '0;
						area_sum_q       <= '0;
						top_flag_q       <= 1'b0;
						bottom_flag_q    <= 1'b0;
						top_count_q      <= '0;
						bottom_count_q   <= '0;
						last_sync_time_q <= head_item.time_us;
					end
					CLS_OVLD: ;
					default: ;
				endcase
			end
		end
	end

	// An overload report carries no particle statistics.
	always_ff @(posedge clk) begin
		if (pop && !is_image) begin
			time_q  <= head_item.time_us;
			delta_q <= delta_d;
			if (head_item.cls == CLS_SYNC) begin
				kind_q       <= KIND_PARTICLE;
				width_q      <= width_count_q;
				height_q     <= height_max_q;
				area_q       <= area_sum_q;
				top_q        <= top_flag_q;
				bottom_q     <= bottom_flag_q;
				top_cnt_q    <= top_count_q;
				bottom_cnt_q <= bottom_count_q;
			end else begin
				kind_q       <= KIND_OVERLOAD;
				width_q      <= '0;
				height_q     <= '0;
				area_q       <= '0;
				top_q        <= 1'b0;
				bottom_q     <= 1'b0;
				top_cnt_q    <= '0;
				bottom_cnt_q <= '0;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign result_kind         = kind_q;
	assign time_us             = time_q;
	assign delta_us            = delta_q;
	assign particle_width      = width_q;
	assign particle_height     = height_q;
	assign particle_area       = area_q;
	assign touched_top_edge    = top_q;
	assign touched_bottom_edge = bottom_q;
	assign top_edge_count      = top_cnt_q;
	assign bottom_edge_count   = bottom_cnt_q;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the particle slice extractor. Probe slices are sent
// through the input handshake with random gaps, or back to back in calm runs.
// A scoreboard tracks the particle state and the register settings on its
// own, and works out the particle or overload report, if any, that each
// accepted slice should produce. Every report that transfers out is checked
// field by field against the oldest one still due.
// ----------------------------------------------------------------------------
module tb_top;
	import pse_pkg::*;

	localparam logic [SliceW-1:0] TimeField = 64'h0000_00FF_FFFF_FFFF;
	localparam logic [SliceW-1:0] AllClear  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int WidthMax    = 65535;
	localparam int AreaMax     = 4194303;
	localparam int EdgeMax     = 65535;
	localparam int ReportLimit = 10;
	localparam int HoldCycles  = 60;
	localparam int RandomItems = 1700;

	typedef struct packed {
		logic               kind;
		logic [TimeW-1:0]   time_us;
		logic [DeltaW-1:0]  delta_us;
		logic [WidthW-1:0]  width;
		logic [HeightW-1:0] height;
		logic [AreaW-1:0]   area;
		logic               top;
		logic               bottom;
		logic [EdgeW-1:0]   top_cnt;
		logic [EdgeW-1:0]   bottom_cnt;
	} particle_report_t;

	class particle_tracker;
		logic [SliceW-1:0] mask;
		logic [SliceW-1:0] sync_pat;
		logic [SliceW-1:0] ovld_pat;
		int                width_cnt;
		int                height_max;
		int                area_sum;
		int                top_cnt;
		int                bottom_cnt;
		logic              top_seen;
		logic              bottom_seen;
		logic [TimeW-1:0]  last_sync;
		particle_report_t  reports_due[$];
		int unsigned       errors;

		function new();
			mask      = SyncMaskReset;
			sync_pat  = '0;
			ovld_pat  = '0;
			last_sync = '0;
			errors    = 0;
			clear_particle();
		endfunction

		function void clear_particle();
			width_cnt   = 0;
			height_max  = 0;
			area_sum    = 0;
			top_cnt     = 0;
			bottom_cnt  = 0;
			top_seen    = 1'b0;
			bottom_seen = 1'b0;
		endfunction

		function void write_reg(logic [CfgIndexW-1:0] idx, logic [SliceW-1:0] value);
			case (idx)
				CFG_SYNC_MASK:        mask = value;
				CFG_SYNC_PATTERN:     sync_pat = value;
				CFG_OVERLOAD_PATTERN: ovld_pat = value;
				default: ;
			endcase
		endfunction

		// Works out what one accepted slice does to the particle and which report,
		// if any, it must produce.
		function void take_slice(logic [SliceW-1:0] s);
			logic [SliceW-1:0] masked;
			logic [SliceW-1:0] ticks;
			logic [SliceW-1:0] shadow;
			particle_report_t  r;
			int                lead;
			int                trail;
			int                span;
			masked = s & mask;
			ticks = (s & TimeField) / 64'd12;
			r = '0;
			r.time_us = ticks[TimeW-1:0];
			r.delta_us = {1'b0, r.time_us} - {1'b0, last_sync};
			if (masked == sync_pat) begin
				// A sync wins when both patterns match.
				r.kind       = KIND_PARTICLE;
				r.width      = width_cnt[WidthW-1:0];
				r.height     = height_max[HeightW-1:0];
				r.area       = area_sum[AreaW-1:0];
				r.top        = top_seen;
				r.bottom     = bottom_seen;
				r.top_cnt    = top_cnt[EdgeW-1:0];
				r.bottom_cnt = bottom_cnt[EdgeW-1:0];
				reports_due.push_back(r);
				last_sync = r.time_us;
				clear_particle();
			end else if (masked == ovld_pat) begin
				// Overload leaves the particle and the last sync time alone.
				r.kind = KIND_OVERLOAD;
				reports_due.push_back(r);
			end else if (s != AllClear) begin
				shadow = ~s;
				if (width_cnt < WidthMax)
					width_cnt++;
				if (shadow[SliceW-1]) begin
					top_seen = 1'b1;
					if (top_cnt < EdgeMax)
						top_cnt++;
				end
				if (shadow[0]) begin
					bottom_seen = 1'b1;
					if (bottom_cnt < EdgeMax)
						bottom_cnt++;
				end
				area_sum = area_sum + $countones(shadow);
				if (area_sum > AreaMax)
					area_sum = AreaMax;
				lead = 0;
				trail = 0;
				for (int j = SliceW - 1; j >= 0; j--)
					if (s[j] && lead == SliceW - 1 - j)
						lead++;
				for (int j = 0; j < SliceW; j++)
					if (s[j] && trail == j)
						trail++;
				span = SliceW - lead - trail;
				if (span > height_max)
					height_max = span;
			end
		endfunction

		function string show(particle_report_t r);
			return $sformatf({"kind %0d time %0d delta %0d width %0d height %0d",
				" area %0d top %0d/%0d bottom %0d/%0d"},
				r.kind, r.time_us, $signed(r.delta_us), r.width, r.height, r.area,
				r.top, r.top_cnt, r.bottom, r.bottom_cnt);
		endfunction

		function void match_report(particle_report_t got);
			particle_report_t want;
			string            bad;
			if (reports_due.size() == 0) begin
				errors++;
				if (errors <= ReportLimit)
					$display("unexpected report: %s", show(got));
				return;
			end
			want = reports_due.pop_front();
			bad = "";
			if (got.kind !== want.kind)             bad = {bad, " kind"};
			if (got.time_us !== want.time_us)       bad = {bad, " time_us"};
			if (got.delta_us !== want.delta_us)     bad = {bad, " delta_us"};
			if (got.width !== want.width)           bad = {bad, " width"};
			if (got.height !== want.height)         bad = {bad, " height"};
			if (got.area !== want.area)             bad = {bad, " area"};
			if (got.top !== want.top)               bad = {bad, " top"};
			if (got.bottom !== want.bottom)         bad = {bad, " bottom"};
			if (got.top_cnt !== want.top_cnt)       bad = {bad, " top_cnt"};
			if (got.bottom_cnt !== want.bottom_cnt) bad = {bad, " bottom_cnt"};
			if (bad != "") begin
				errors++;
				if (errors <= ReportLimit) begin
					$display("report mismatch in%s at %0t", bad, $realtime);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [SliceW-1:0]          slice_bits;
	logic                       cfg_write;
	logic [CfgIndexW-1:0]       cfg_index;
	logic [SliceW-1:0]          cfg_data;
	logic                       out_valid;
	logic                       out_stall;
	logic                       result_kind;
	logic [TimeW-1:0]           time_us;
	logic signed [DeltaW-1:0]   delta_us;
	logic [WidthW-1:0]          particle_width;
	logic [HeightW-1:0]         particle_height;
	logic [AreaW-1:0]           particle_area;
	logic                       touched_top_edge;
	logic                       touched_bottom_edge;
	logic [EdgeW-1:0]           top_edge_count;
	logic [EdgeW-1:0]           bottom_edge_count;

	particle_tracker  board;
	particle_report_t seen;
	bit               calm;
	bit               hold_req;
	int               sent;

	particle_slice_extractor_64_unit uut (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("** particle_slice_extractor_64_unit: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.kind       = result_kind;
			seen.time_us    = time_us;
			seen.delta_us   = delta_us;
			seen.width      = particle_width;
			seen.height     = particle_height;
			seen.area       = particle_area;
			seen.top        = touched_top_edge;
			seen.bottom     = touched_bottom_edge;
			seen.top_cnt    = top_edge_count;
			seen.bottom_cnt = bottom_edge_count;
			board.match_report(seen);
		end
	end

	// Result side: a random stall before each transfer, or one long hold-off
	// when the stimulus asks for it.
	initial begin : receiver
		int wait_cycles;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				wait_cycles = calm ? 0 : $urandom_range(0, 5);
				if (wait_cycles > 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	function automatic logic [SliceW-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// A word whose compared bits carry the given pattern; the rest is random.
	function automatic logic [SliceW-1:0] marked_word(logic [SliceW-1:0] pattern);
		return (rand64() & ~board.mask) | (pattern & board.mask);
	endfunction

	function automatic logic [SliceW-1:0] image_word();
		int                lo;
		int                hi;
		int                shape;
		logic [SliceW-1:0] run;
		shape = $urandom_range(0, 7);
		lo = $urandom_range(0, SliceW - 1);
		hi = $urandom_range(lo, SliceW - 1);
		if (shape == 0)
			return rand64();
		if (shape == 1)
			return '0;
		if (shape == 2)
			lo = 0;
		if (shape == 3)
			hi = SliceW - 1;
		run = ((64'd1 << (hi - lo + 1)) - 64'd1) << lo;
		if (shape >= 4)
			run = run & (rand64() | rand64());
		return ~run;
	endfunction

	task automatic send_slice(input logic [SliceW-1:0] value);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		slice_bits <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.take_slice(value);
		sent++;
	endtask

	// Stops offering slices until every report due has transferred and the
	// pipeline has had time to finish slices that produce none.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.reports_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(input logic [SliceW-1:0] mask, input logic [SliceW-1:0] sync,
			input logic [SliceW-1:0] ovld);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= CFG_SYNC_MASK;
		cfg_data <= mask;
		@(posedge clk);
		cfg_index <= CFG_SYNC_PATTERN;
		cfg_data <= sync;
		@(posedge clk);
		cfg_index <= CFG_OVERLOAD_PATTERN;
		cfg_data <= ovld;
		@(posedge clk);
		cfg_write <= 1'b0;
		board.write_reg(CFG_SYNC_MASK, mask);
		board.write_reg(CFG_SYNC_PATTERN, sync);
		board.write_reg(CFG_OVERLOAD_PATTERN, ovld);
	endtask

	task automatic random_config();
		logic [SliceW-1:0] m;
		case ($urandom_range(0, 3))
			0: m = AllClear << (SliceW - $urandom_range(4, 40));
			1: m = rand64();
			2: m = AllClear;
			default: m = SyncMaskReset;
		endcase
		set_config(m, rand64() & m, rand64() & m);
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		slice_bits <= '0;
		cfg_write <= 1'b0;
		cfg_index <= CFG_SYNC_MASK;
		cfg_data <= '0;
		calm = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a word is a sync when its top 24 bits are zero.
		send_slice(64'h8000_0000_0000_0000);
		send_slice(AllClear);
		send_slice(64'h7FFF_FFFF_FFFF_FFFE);
		send_slice(64'hFFFF_FFFF_FFFF_FFFE);
		send_slice(64'h7FFF_FFFF_FFFF_FFFF);
		// First sync ever, with the largest time word.
		send_slice(64'h0000_00FF_FFFF_FFFF);
		// Time drops back to zero, so the difference goes negative.
		send_slice(64'h0000_0000_0000_000B);
		send_slice(64'h0000_0000_0000_000C);

		set_config(SyncMaskReset, 64'h5A5A_5A00_0000_0000, 64'hC3C3_C300_0000_0000);
		send_slice(64'hC3C3_C3FF_FFFF_FFFF);
		send_slice(64'h0000_0000_0000_0000);
		send_slice(64'hC3C3_C300_0000_0000);
		send_slice(64'hFFFF_F000_000F_FFFF);
		send_slice(64'h5A5A_5A12_3456_789A);

		// Both patterns equal: only the particle is reported.
		set_config(SyncMaskReset, 64'h3C3C_3C00_0000_0000, 64'h3C3C_3C00_0000_0000);
		send_slice(64'h3C3C_3C00_0000_1234);

		// Overload pattern with a bit outside the mask can never match.
		set_config(SyncMaskReset, 64'h1111_1100_0000_0000, 64'h2222_2200_0000_0001);
		send_slice(64'h2222_2200_0000_0001);
		send_slice(64'h1111_1100_0000_0000);

		// Empty mask: every word, all-clear included, is a sync.
		set_config('0, '0, '0);
		send_slice(AllClear);
		send_slice(rand64());

		// Full mask with an all-ones sync pattern.
		set_config(AllClear, AllClear, '0);
		send_slice(AllClear);
		send_slice('0);
		send_slice(64'hFFFF_FFFF_FFFF_FFFE);
		send_slice(AllClear);

		// Hold the result side off while syncs keep coming, so the queue fills.
		set_config(SyncMaskReset, rand64() & SyncMaskReset, rand64() & SyncMaskReset);
		hold_req = 1'b1;
		calm = 1'b1;
		repeat (40) send_slice(marked_word(board.sync_pat));
		calm = 1'b0;
		drain();

		sent = 0;
		while (sent < RandomItems) begin
			if ($urandom_range(0, 59) == 0)
				random_config();
			if ($urandom_range(0, 19) == 0)
				calm = ~calm;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: begin
					repeat ($urandom_range(0, 8)) begin
						case ($urandom_range(0, 19))
							0: send_slice(AllClear);
							1: send_slice(marked_word(board.ovld_pat));
							default: send_slice(image_word());
						endcase
					end
					send_slice(marked_word(board.sync_pat));
				end
				7: send_slice(marked_word(board.ovld_pat));
				8: repeat ($urandom_range(1, 4)) send_slice(rand64());
				default: begin
					if ($urandom_range(0, 3) == 0)
						drain();
					else
						send_slice(AllClear);
				end
			endcase
		end
		calm = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.reports_due.size() == 0)
			$display("** particle_slice_extractor_64_unit: PASSED **");
		else
			$display("** particle_slice_extractor_64_unit: FAILED **");
		$finish;
	end

endmodule
